/* rtl/core/rdsu_pkg.sv */
// Shared types and command codes for the pipelined restoring divider.
package rdsu_pkg;

  // Operation selected by an item.
  typedef enum logic [1:0] {
    CMD_UQUOT = 2'd0,
    CMD_UREM  = 2'd1,
    CMD_SQUOT = 2'd2,
    CMD_SREM  = 2'd3
  } cmd_t;

  // Control flags that travel with each item down the pipeline.
  typedef struct packed {
    logic valid;
    logic is_rem;
    logic neg_res;
    logic zero;
  } ctrl_t;

endpackage

/* rtl/core/rdsu_prep.sv */
// Operand stage: decode the command, take magnitudes, flag a zero divisor.
module rdsu_prep #(
  parameter int WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic [1:0]            command,
  input  logic [WIDTH-1:0]      dividend,
  input  logic [WIDTH-1:0]      divisor,
  output logic [WIDTH-1:0]      num_r,
  output logic [WIDTH-1:0]      den_r,
  output rdsu_pkg::ctrl_t       ctrl_r
);

  rdsu_pkg::cmd_t  cmd;
  logic            is_signed;
  logic            num_neg;
  logic            den_neg;
  logic [WIDTH-1:0] num_nxt;
  logic [WIDTH-1:0] den_nxt;
  rdsu_pkg::ctrl_t ctrl_nxt;

  // Decode and take magnitudes for signed commands
  always_comb begin
    cmd                = rdsu_pkg::cmd_t'(command);
    is_signed          = (cmd == rdsu_pkg::CMD_SQUOT) || (cmd == rdsu_pkg::CMD_SREM);
    num_neg            = is_signed && dividend[WIDTH-1];
    den_neg            = is_signed && divisor[WIDTH-1];
    num_nxt            = num_neg ? (-dividend) : dividend;
    den_nxt            = den_neg ? (-divisor) : divisor;
    ctrl_nxt.valid     = take;
    ctrl_nxt.is_rem    = (cmd == rdsu_pkg::CMD_UREM) || (cmd == rdsu_pkg::CMD_SREM);
    ctrl_nxt.neg_res   = ctrl_nxt.is_rem ? num_neg : (num_neg ^ den_neg);
    ctrl_nxt.zero      = (divisor == '0);
  end

  // Hold operands
  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
  end

  // Advance control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl_nxt;
    end
  end

endmodule

/* rtl/core/rdsu_step.sv */
// One restoring division step: shift in a dividend bit, subtract when it fits.
module rdsu_step #(
  parameter int WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [WIDTH-1:0]      rem,
  input  logic [WIDTH-1:0]      nq,
  input  logic [WIDTH-1:0]      den,
  input  rdsu_pkg::ctrl_t       ctrl,
  output logic [WIDTH-1:0]      rem_r,
  output logic [WIDTH-1:0]      nq_r,
  output logic [WIDTH-1:0]      den_r,
  output rdsu_pkg::ctrl_t       ctrl_r
);

  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             fits;
  logic [WIDTH-1:0] rem_nxt;
  logic [WIDTH-1:0] nq_nxt;

  // Trial subtract; the top bit of the difference is the borrow
  always_comb begin
    shifted = {rem, nq[WIDTH-1]};
    diff    = shifted - {1'b0, den};
    fits    = !diff[WIDTH];
    rem_nxt = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
    nq_nxt  = {nq[WIDTH-2:0], fits};
  end

  // Hold the partial remainder, the dividend/quotient word and the divisor
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    nq_r  <= nq_nxt;
    den_r <= den;
  end

  // Advance control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl;
    end
  end

endmodule

/* rtl/core/rdsu_fix.sv */
// Result stage: pick quotient or remainder, apply sign, zero for a zero divisor.
module rdsu_fix #(
  parameter int WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [WIDTH-1:0]      rem,
  input  logic [WIDTH-1:0]      quot,
  input  rdsu_pkg::ctrl_t       ctrl,
  output logic                  valid_r,
  output logic [WIDTH-1:0]      result_r
);

  logic [WIDTH-1:0] pick;
  logic [WIDTH-1:0] result_nxt;

  // Select and negate
  always_comb begin
    pick = ctrl.is_rem ? rem : quot;
    if (ctrl.zero) begin
      result_nxt = '0;
    end else if (ctrl.neg_res) begin
      result_nxt = -pick;
    end else begin
      result_nxt = pick;
    end
  end

  // Hold the result
  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  // Raise the strobe for one cycle per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctrl.valid;
    end
  end

endmodule

/* rtl/core/restoring_divider_signed_unsigned_top.sv */
// Top level of the pipelined signed/unsigned restoring divider.
// Takes one item in every cycle: busy stays low, so an item is accepted on any
// edge with start high. Each result appears on out_result with out_valid high
// for one cycle, once its item has passed through one operand stage,
// one register stage per quotient bit (a WIDTH+1 bit trial subtract each), and
// one sign/select stage. Results leave in the order items came in and must be
// taken when shown. A zero divisor gives 0; the signed minimum over -1 gives
// the signed minimum with remainder 0.
module restoring_divider_signed_unsigned_top #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_command,
  input  logic [WIDTH-1:0] in_dividend,
  input  logic [WIDTH-1:0] in_divisor,
  output logic             out_valid,
  output logic [WIDTH-1:0] out_result
);

  localparam int LAT = WIDTH + 2;

  logic [WIDTH-1:0] rem_s  [0:WIDTH];
  logic [WIDTH-1:0] nq_s   [0:WIDTH];
  logic [WIDTH-1:0] den_s  [0:WIDTH];
  rdsu_pkg::ctrl_t  ctrl_s [0:WIDTH];

  // The pipeline never stalls
  assign busy = 1'b0;

  // Operand stage
  rdsu_prep #(.WIDTH(WIDTH)) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (start && !busy),
    .command  (in_command),
    .dividend (in_dividend),
    .divisor  (in_divisor),
    .num_r    (nq_s[0]),
    .den_r    (den_s[0]),
    .ctrl_r   (ctrl_s[0])
  );

  assign rem_s[0] = '0;

  // One stage per quotient bit, MSB first
  for (genvar g = 0; g < WIDTH; g++) begin : g_step
    rdsu_step #(.WIDTH(WIDTH)) u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .rem    (rem_s[g]),
      .nq     (nq_s[g]),
      .den    (den_s[g]),
      .ctrl   (ctrl_s[g]),
      .rem_r  (rem_s[g+1]),
      .nq_r   (nq_s[g+1]),
      .den_r  (den_s[g+1]),
      .ctrl_r (ctrl_s[g+1])
    );
  end

  // Result stage
  rdsu_fix #(.WIDTH(WIDTH)) u_fix (
    .clk      (clk),
    .rst_n    (rst_n),
    .rem      (rem_s[WIDTH]),
    .quot     (nq_s[WIDTH]),
    .ctrl     (ctrl_s[WIDTH]),
    .valid_r  (out_valid),
    .result_r (out_result)
  );

  // Every accepted item yields a result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted item did not produce a result on time");

  // No result strobe without a matching accepted item
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result strobe without a matching item");

  // A zero divisor gives a zero result
  a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(start && !busy && (in_divisor == '0), LAT)) |-> (out_result == '0))
    else $error("zero divisor gave a nonzero result");

endmodule

/* dv/tb_restoring_divider_signed_unsigned_top.sv */
// Testbench for the pipelined signed/unsigned restoring divider, self-checking.
`timescale 1ns / 100ps

module tb_restoring_divider_signed_unsigned_top;

  localparam int WIDTH = 32;
  localparam int LATENCY = WIDTH + 2;
  localparam int STALL_LIMIT = 2000;

  typedef logic [WIDTH-1:0] word_t;

  // One item in flight and the value it must produce.
  typedef struct {
    rdsu_pkg::cmd_t op;
    word_t          num;
    word_t          den;
    word_t          value;
  } div_expect_t;

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  logic  [1:0] in_command;
  word_t in_dividend;
  word_t in_divisor;
  logic  out_valid;
  word_t out_result;

  div_expect_t pending_results[$];
  int          mismatch_count;
  int          quiet_cycles;
  bit          idling_on;

  restoring_divider_signed_unsigned_top #(
    .WIDTH(WIDTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_command (in_command),
    .in_dividend(in_dividend),
    .in_divisor (in_divisor),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  // Free-running clock, 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Quotient or remainder that a command selects; zero divisor gives 0.
  function automatic word_t divide_result(rdsu_pkg::cmd_t op, word_t num, word_t den);
    logic  num_neg;
    logic  den_neg;
    word_t mag_num;
    word_t mag_den;
    word_t quot;
    word_t rem;
    if (den == '0) return '0;
    if (op == rdsu_pkg::CMD_UQUOT || op == rdsu_pkg::CMD_UREM) begin
      num_neg = 1'b0;
      den_neg = 1'b0;
    end else begin
      num_neg = num[WIDTH-1];
      den_neg = den[WIDTH-1];
    end
    // Divide magnitudes; the signed minimum keeps 2^(WIDTH-1) as magnitude.
    mag_num = num_neg ? word_t'(-num) : num;
    mag_den = den_neg ? word_t'(-den) : den;
    quot = mag_num / mag_den;
    rem  = mag_num % mag_den;
    case (op)
      rdsu_pkg::CMD_UQUOT: return quot;
      rdsu_pkg::CMD_UREM:  return rem;
      rdsu_pkg::CMD_SQUOT: return (num_neg ^ den_neg) ? word_t'(-quot) : quot;
      default:             return num_neg ? word_t'(-rem) : rem;
    endcase
  endfunction

  // Check each result against the oldest item, record accepted items,
  // and stop the run if nothing moves for too long.
  always @(posedge clk) begin
    div_expect_t head;
    div_expect_t item;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result %h with no item in flight", out_result);
        end else begin
          head = pending_results.pop_front();
          if (out_result !== head.value) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: %s %h / %h expected %h got %h",
                       head.op.name(), head.num, head.den, head.value, out_result);
          end
        end
      end
      if (start && !busy) begin
        item.op    = rdsu_pkg::cmd_t'(in_command);
        item.num   = in_dividend;
        item.den   = in_divisor;
        item.value = divide_result(item.op, in_dividend, in_divisor);
        pending_results.push_back(item);
      end
      if ((start && !busy) || out_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no item or result for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Present one item and hold it until the block takes it.
  task automatic send_item(rdsu_pkg::cmd_t op, word_t num, word_t den);
    start       <= 1'b1;
    in_command  <= op;
    in_dividend <= num;
    in_divisor  <= den;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start for a number of cycles.
  task automatic idle_gap(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop start and wait until every item in flight has produced its result.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Operand with a spread of magnitudes, small values and sign extremes.
  function automatic word_t pick_operand();
    case ($urandom_range(0, 6))
      0:       return word_t'($urandom_range(0, 15));
      1:       return word_t'(-$urandom_range(1, 16));
      2:       return {1'b1, {(WIDTH-1){1'b0}}} + word_t'($urandom_range(0, 3));
      3:       return {1'b0, {(WIDTH-1){1'b1}}} - word_t'($urandom_range(0, 3));
      4:       return word_t'($urandom) >> $urandom_range(0, WIDTH-1);
      default: return word_t'($urandom);
    endcase
  endfunction

  // Send one random item, mostly ordinary and sometimes a special case.
  task automatic send_random_item();
    rdsu_pkg::cmd_t op;
    word_t          num;
    word_t          den;
    op  = rdsu_pkg::cmd_t'($urandom_range(0, 3));
    num = pick_operand();
    den = pick_operand();
    case ($urandom_range(0, 15))
      0: den = '0;
      1: begin
        num = {1'b1, {(WIDTH-1){1'b0}}};
        den = '1;
      end
      2: den = word_t'($urandom_range(1, 3));
      default: ;
    endcase
    send_item(op, num, den);
  endtask

  // Extremes of every field, every command and each special case.
  task automatic test_directed();
    rdsu_pkg::cmd_t op;
    for (int c = 0; c < 4; c++) begin
      op = rdsu_pkg::cmd_t'(c);
      send_item(op, 32'd0, 32'd0);
      send_item(op, 32'hFFFF_FFFF, 32'd0);
      send_item(op, 32'h8000_0000, 32'hFFFF_FFFF);
      send_item(op, 32'hFFFF_FFFF, 32'd1);
    end
    send_item(rdsu_pkg::CMD_UQUOT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(rdsu_pkg::CMD_UREM,  32'd5, 32'hFFFF_FFFF);
    send_item(rdsu_pkg::CMD_SQUOT, 32'hFFFF_FFF9, 32'd2);
    send_item(rdsu_pkg::CMD_SREM,  32'hFFFF_FFF9, 32'd2);
    send_item(rdsu_pkg::CMD_SQUOT, 32'd7, 32'hFFFF_FFFE);
    send_item(rdsu_pkg::CMD_SREM,  32'd7, 32'hFFFF_FFFE);
    send_item(rdsu_pkg::CMD_SQUOT, 32'h8000_0000, 32'h8000_0000);
    send_item(rdsu_pkg::CMD_SREM,  32'h7FFF_FFFF, 32'h8000_0000);
    send_item(rdsu_pkg::CMD_UREM,  32'h8000_0000, 32'h7FFF_FFFF);
  endtask

  // Random items with bursts of idle cycles, switched on and off in stretches.
  task automatic test_random_idling(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) idling_on = ($urandom_range(0, 2) != 0);
      if (idling_on && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 7));
      send_random_item();
    end
  endtask

  // Let the pipeline empty completely between groups of items.
  task automatic test_drain_pause(int groups);
    for (int g = 0; g < groups; g++) begin
      repeat ($urandom_range(1, 12)) send_random_item();
      wait_drained();
    end
  endtask

  // Back-to-back items with no gaps at all.
  task automatic test_back_to_back(int count);
    repeat (count) send_random_item();
  endtask

  initial begin
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_command     <= rdsu_pkg::CMD_UQUOT;
    in_dividend    <= '0;
    in_divisor     <= '0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    idling_on      = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_idling(400);
    test_drain_pause(10);
    test_back_to_back(120);

    // Hold until all results are in, then watch for stray ones.
    wait_drained();
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
